// ----- src/hng_pkg.sv -----
package hng_pkg;

  localparam int SAMPLE_W = 8;
  localparam int ENTRY_W  = 9;
  localparam int HGT_W    = 9;
  localparam int DIFF_W   = 10;
  localparam int COL_W    = 11;
  localparam int ROW_W    = 16;
  localparam int RL_W     = 12;
  localparam int GAIN_W   = 16;
  localparam int SCALE_W  = 16;
  localparam int HOUT_W   = 16;
  localparam int VMAG_W   = 26;
  localparam int PM_W     = 24;
  localparam int HNUM_W   = 25;
  localparam int HREC_W   = 26;
  localparam int HPROD_W  = 51;
  localparam int H_SHIFT  = 33;
  localparam int SQ_W     = 52;
  localparam int DEN_W    = 26;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int QDEPTH   = 2;

  localparam logic [VMAG_W-1:0] VY_SCALE  = 26'd65280;
  localparam logic [SQ_W-1:0]   VY_SQ     = 52'd4261478400;
  localparam logic [SQ_W-1:0]   ROOT_TOP  = 52'h4000000000000;
  // floor(x / 255) = (x * H_RECIP) >> H_SHIFT for every x below 2^25
  localparam logic [HREC_W-1:0] H_RECIP   = 26'd33686019;
  // (2*pm + 255) / 510 rounds the same as (pm + 127) / 255
  localparam logic [HNUM_W-1:0] H_ROUND   = 25'd127;

  localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
  localparam logic [1:0] REG_NORMAL_GAIN  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  localparam logic [RL_W-1:0]    ROW_LENGTH_RST   = 12'd2049;
  localparam logic [GAIN_W-1:0]  NORMAL_GAIN_RST  = 16'd2560;
  localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 16'd256;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
    logic signed [HGT_W-1:0]  ac;
    logic [COL_W-1:0]         column;
    logic [ROW_W-1:0]         row;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } qlink_t;

  // entry is {in_image, sample}; height a = 2r-255, zero out of image
  function automatic logic signed [HGT_W-1:0] entry_height(input logic [ENTRY_W-1:0] e);
    logic signed [HGT_W:0] t;
    t = $signed({1'b0, e[SAMPLE_W-1:0], 1'b0}) - 10'sd255;
    return e[SAMPLE_W] ? t[HGT_W-1:0] : '0;
  endfunction

endpackage

// ----- src/hng_in_if.sv -----
interface hng_in_if;
  import hng_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                out_of_image;
  modport source (output valid, sample, out_of_image, input ready);
  modport sink (input valid, sample, out_of_image, output ready);
endinterface

// ----- src/hng_out_if.sv -----
interface hng_out_if #(parameter int NORMAL_BITS = 16);
  import hng_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [COL_W-1:0]              column;
  logic [ROW_W-1:0]              row;
  logic signed [NORMAL_BITS-1:0] normal_x;
  logic [NORMAL_BITS-2:0]        normal_y;
  logic signed [NORMAL_BITS-1:0] normal_z;
  logic signed [HOUT_W-1:0]      scaled_height;
  modport source (output valid, column, row, normal_x, normal_y, normal_z, scaled_height,
                  input ready);
  modport sink (input valid, column, row, normal_x, normal_y, normal_z, scaled_height,
                output ready);
endinterface

// ----- src/hng_front.sv -----
module hng_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                    clk,
  input  logic                    rst_n,
  hng_in_if.sink                  in_ch,
  input  logic [hng_pkg::RL_W-1:0] row_length,
  output hng_pkg::qlink_t         push,
  output hng_pkg::job_t           push_job,
  input  logic                    q_space
);
  import hng_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (CW + 1 > RL_W) ? CW + 1 : RL_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WIDTH + 1);
  localparam logic [LW-1:0] LEN_MIN = LW'(2);

  typedef enum logic {F_IDLE, F_LOOK} fstate_t;

  fstate_t            state_r;
  logic [CW-1:0]      c_r;
  logic [ROW_W-1:0]   row_r;
  logic [ENTRY_W-1:0] cur_r, wl_r, wc_r, wd_r, last_r;
  logic [ENTRY_W-1:0] prev_q_r, older_q_r;
  logic               cval_r;

  logic [ENTRY_W-1:0] prev_mem  [MAX_WIDTH];
  logic [ENTRY_W-1:0] older_mem [MAX_WIDTH];

  logic               accept;
  logic [ENTRY_W-1:0] e_r, e_d;
  logic signed [HGT_W-1:0] al, ar, ad, au, ac;
  logic [LW-1:0]      len_eff, rl_ext;
  logic [CW:0]        c_inc;
  logic               wrap, produce;
  logic [CW-1:0]      c_m1;

  assign in_ch.ready = (state_r == F_IDLE) && q_space;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    e_r = cval_r ? prev_q_r : '0;
    e_d = cval_r ? older_q_r : '0;
    al  = (c_r == CW'(1)) ? '0 : entry_height(wl_r);
    ar  = entry_height(e_r);
    ad  = (row_r < ROW_W'(2)) ? '0 : entry_height(wd_r);
    au  = entry_height(last_r);
    ac  = entry_height(wc_r);
    rl_ext = LW'(row_length);
    if (rl_ext < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (rl_ext > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = rl_ext;
    end
    c_inc   = {1'b0, c_r} + (CW+1)'(1);
    wrap    = LW'(c_inc) >= len_eff;
    produce = (state_r == F_LOOK) && (c_r != '0) && (row_r != '0) && wc_r[SAMPLE_W];
    c_m1    = c_r - CW'(1);
  end

  assign push.valid      = produce;
  assign push.ready      = q_space;
  assign push_job.dx     = $signed({al[HGT_W-1], al}) - $signed({ar[HGT_W-1], ar});
  assign push_job.dz     = $signed({ad[HGT_W-1], ad}) - $signed({au[HGT_W-1], au});
  assign push_job.ac     = ac;
  assign push_job.column = COL_W'(c_m1);
  assign push_job.row    = row_r - ROW_W'(1);

  // two line stores, read at the accept edge, written in the look state that follows
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_q_r  <= prev_mem[c_r[AW-1:0]];
      older_q_r <= older_mem[c_r[AW-1:0]];
    end
    if (state_r == F_LOOK && cval_r) begin
      prev_mem[c_r[AW-1:0]]  <= cur_r;
      older_mem[c_r[AW-1:0]] <= prev_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r  <= in_ch.out_of_image ? '0 : {1'b1, in_ch.sample};
      cval_r <= (CW+1)'(c_r) < (CW+1)'(MAX_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      c_r     <= '0;
      row_r   <= '0;
      wl_r    <= '0;
      wc_r    <= '0;
      wd_r    <= '0;
      last_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_LOOK;
          end
        end
        F_LOOK: begin
          wl_r   <= wc_r;
          wc_r   <= e_r;
          wd_r   <= e_d;
          last_r <= cur_r;
          if (wrap) begin
            c_r   <= '0;
            row_r <= row_r + ROW_W'(1);
          end else begin
            c_r <= c_inc[CW-1:0];
          end
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- src/hng_fifo.sv -----
module hng_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  hng_pkg::qlink_t push,
  input  hng_pkg::job_t   push_job,
  output logic            space,
  input  logic            pop,
  output logic            pop_valid,
  output hng_pkg::job_t   pop_job
);
  import hng_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          q_mem [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push, do_pop;

  assign space     = count_r < (PW+1)'(QDEPTH);
  assign pop_valid = count_r != '0;
  assign pop_job   = q_mem[rd_ptr_r];
  assign do_push   = push.valid && space;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

// ----- src/hng_back.sv -----
module hng_back #(
  parameter int NORMAL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  hng_pkg::job_t                job,
  output logic                         pop,
  input  logic [hng_pkg::GAIN_W-1:0]   normal_gain,
  input  logic [hng_pkg::SCALE_W-1:0]  height_scale,
  hng_out_if.source                    out_ch
);
  import hng_pkg::*;

  localparam int NB    = NORMAL_BITS;
  localparam int QB    = (NB > 18) ? NB - 1 : 17;
  localparam int NUMW  = DEN_W + NB - 1;
  localparam int CNT_W = $clog2(QB + 1);
  localparam logic [QB-1:0] ONE_Q = QB'(1) << (NB - 2);

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SQ, B_SUM, B_ROOT, B_DSET, B_DIV, B_OUT
  } bstate_t;

  bstate_t           state_r;
  job_t              job_r;
  logic              xneg_r, zneg_r, hneg_r;
  logic [VMAG_W-1:0] vx_r, vz_r;
  logic [PM_W-1:0]   pm_r;
  logic [HOUT_W:0]   hq_r;
  logic [SQ_W-1:0]   sqx_r, sqz_r, rem_r, res_r, bit_r;
  logic [DEN_W-1:0]  drem_r [3];
  logic [QB-1:0]     dlow_r [3];
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic signed [NB-1:0]     nx_r, nz_r;
  logic [NB-2:0]            ny_r;
  logic signed [HOUT_W-1:0] sh_r;

  logic [DIFF_W-2:0] mx, mz;
  logic [SAMPLE_W-1:0] mh;
  logic [HNUM_W-1:0] hnum;
  logic [HPROD_W-1:0] hprod;
  logic [SQ_W-1:0]   root_t, rem_n, res_n;
  logic              root_ge;
  logic [NUMW-1:0]   num [3];
  logic [DEN_W-1:0]  den [3];
  logic [DEN_W:0]    dt [3];
  logic              dge [3];
  logic [QB-1:0]     qx, qy, qz;

  assign pop                  = (state_r == B_IDLE) && job_valid;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.column        = col_r;
  assign out_ch.row           = row_r;
  assign out_ch.normal_x      = nx_r;
  assign out_ch.normal_y      = ny_r;
  assign out_ch.normal_z      = nz_r;
  assign out_ch.scaled_height = sh_r;

  always_comb begin
    mx = job_r.dx[DIFF_W-1] ? (DIFF_W-1)'(-job_r.dx) : (DIFF_W-1)'(job_r.dx);
    mz = job_r.dz[DIFF_W-1] ? (DIFF_W-1)'(-job_r.dz) : (DIFF_W-1)'(job_r.dz);
    mh = job_r.ac[HGT_W-1] ? SAMPLE_W'(-job_r.ac) : SAMPLE_W'(job_r.ac);

    // rounded height quotient by reciprocal multiplication
    hnum  = HNUM_W'(pm_r) + H_ROUND;
    hprod = HPROD_W'(hnum) * HPROD_W'(H_RECIP);

    // one bit of the square root per cycle
    root_t  = res_r + bit_r;
    root_ge = rem_r >= root_t;
    rem_n   = root_ge ? rem_r - root_t : rem_r;
    res_n   = root_ge ? (res_r >> 1) + bit_r : res_r >> 1;

    num[0] = (NUMW'(vx_r) << (NB - 2)) + NUMW'(res_r[DEN_W-1:0] >> 1);
    num[1] = (NUMW'(VY_SCALE) << (NB - 2)) + NUMW'(res_r[DEN_W-1:0] >> 1);
    num[2] = (NUMW'(vz_r) << (NB - 2)) + NUMW'(res_r[DEN_W-1:0] >> 1);
    den[0] = res_r[DEN_W-1:0];
    den[1] = res_r[DEN_W-1:0];
    den[2] = res_r[DEN_W-1:0];
    for (int k = 0; k < 3; k++) begin
      dt[k]  = {drem_r[k], dlow_r[k][QB-1]};
      dge[k] = dt[k] >= {1'b0, den[k]};
    end

    qx = (dlow_r[0] > ONE_Q) ? ONE_Q : dlow_r[0];
    qy = (dlow_r[1] > ONE_Q) ? ONE_Q : dlow_r[1];
    qz = (dlow_r[2] > ONE_Q) ? ONE_Q : dlow_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          xneg_r  <= job_r.dx[DIFF_W-1];
          zneg_r  <= job_r.dz[DIFF_W-1];
          hneg_r  <= job_r.ac[HGT_W-1];
          vx_r    <= VMAG_W'({{(VMAG_W-GAIN_W){1'b0}}, normal_gain} *
                             {{(VMAG_W-DIFF_W+1){1'b0}}, mx});
          vz_r    <= VMAG_W'({{(VMAG_W-GAIN_W){1'b0}}, normal_gain} *
                             {{(VMAG_W-DIFF_W+1){1'b0}}, mz});
          pm_r    <= PM_W'({{(PM_W-SCALE_W){1'b0}}, height_scale} *
                           {{(PM_W-SAMPLE_W){1'b0}}, mh});
          state_r <= B_SQ;
        end
        B_SQ: begin
          sqx_r   <= {{(SQ_W-VMAG_W){1'b0}}, vx_r} * {{(SQ_W-VMAG_W){1'b0}}, vx_r};
          sqz_r   <= {{(SQ_W-VMAG_W){1'b0}}, vz_r} * {{(SQ_W-VMAG_W){1'b0}}, vz_r};
          hq_r    <= (HOUT_W+1)'(hprod >> H_SHIFT);
          state_r <= B_SUM;
        end
        B_SUM: begin
          rem_r   <= sqx_r + sqz_r + VY_SQ;
          res_r   <= '0;
          bit_r   <= ROOT_TOP;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          rem_r <= rem_n;
          res_r <= res_n;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= B_DSET;
          end
        end
        B_DSET: begin
          for (int k = 0; k < 3; k++) begin
            drem_r[k] <= DEN_W'(num[k] >> QB);
            dlow_r[k] <= num[k][QB-1:0];
          end
          cnt_r   <= CNT_W'(QB);
          state_r <= B_DIV;
        end
        B_DIV: begin
          for (int k = 0; k < 3; k++) begin
            drem_r[k] <= dge[k] ? DEN_W'(dt[k] - {1'b0, den[k]}) : DEN_W'(dt[k]);
            dlow_r[k] <= {dlow_r[k][QB-2:0], dge[k]};
          end
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_r) begin
            col_r <= job_r.column;
            row_r <= job_r.row;
            nx_r  <= xneg_r ? -$signed(NB'(qx)) : $signed(NB'(qx));
            ny_r  <= (NB-1)'(qy);
            nz_r  <= zneg_r ? -$signed(NB'(qz)) : $signed(NB'(qz));
            if (hneg_r) begin
              sh_r <= (hq_r >= (HOUT_W+1)'(32768)) ? 16'sh8000 : -$signed(HOUT_W'(hq_r));
            end else begin
              sh_r <= (hq_r > (HOUT_W+1)'(32767)) ? 16'sh7fff : $signed(HOUT_W'(hq_r));
            end
            out_valid_r <= 1'b1;
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/heightmap_normal_generator.sv -----
// heightmap normal generator: takes 8-bit height samples in raster order, each row
// carrying row_length items (last one a padding column) and one padding row after the
// image, and for every in-image pixel returns, one row and one column behind the
// stream, the central-difference surface normal in signed fixed point
// (one bit = 2^-(NORMAL_BITS-2)) plus the pixel height times height_scale in
// saturated signed q8.8. the front takes an item only while idle with queue space,
// and after each item it spends a look state on the registered read of the two line
// stores; results are computed by a shared back end (26 square-root steps plus 17
// divide steps, more when NORMAL_BITS exceeds 18), which takes a new job only after
// the last result has been taken, while padding items pass the front without a job. a two-entry
// queue sits between front and back. configuration goes through an apb-style
// port: row_length at 0x0, normal_gain at 0x4, height_scale at 0x8. these must be
// written only while the block is idle; the block itself does not enforce this.
// line stores are not cleared at reset; the first rows are masked instead.
module heightmap_normal_generator #(
  parameter int MAX_WIDTH   = 2048,
  parameter int NORMAL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hng_in_if.sink                      in_ch,
  hng_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hng_pkg::PADDR_W-1:0] paddr,
  input  logic [hng_pkg::PDATA_W-1:0] pwdata,
  output logic [hng_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import hng_pkg::*;

  // configuration registers
  logic [RL_W-1:0]    row_length_r;
  logic [GAIN_W-1:0]  normal_gain_r;
  logic [SCALE_W-1:0] height_scale_r;
  logic               cfg_wr;

  // front to queue to back
  qlink_t push;
  job_t   push_job, pop_job;
  logic   q_space, pop, pop_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register write, decoded on the word address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r   <= ROW_LENGTH_RST;
      normal_gain_r  <= NORMAL_GAIN_RST;
      height_scale_r <= HEIGHT_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROW_LENGTH:   row_length_r   <= pwdata[RL_W-1:0];
        REG_NORMAL_GAIN:  normal_gain_r  <= pwdata[GAIN_W-1:0];
        REG_HEIGHT_SCALE: height_scale_r <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_LENGTH:   prdata = PDATA_W'(row_length_r);
      REG_NORMAL_GAIN:  prdata = PDATA_W'(normal_gain_r);
      REG_HEIGHT_SCALE: prdata = PDATA_W'(height_scale_r);
      default:          prdata = '0;
    endcase
  end

  // stencil window and line stores
  hng_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .row_length (row_length_r),
    .push       (push),
    .push_job   (push_job),
    .q_space    (q_space)
  );

  // short job queue so the front keeps taking items while a result waits
  hng_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .space     (q_space),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  // gain multiply, square root, normalize and height scaling
  hng_back #(.NORMAL_BITS(NORMAL_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (pop_valid),
    .job          (pop_job),
    .pop          (pop),
    .normal_gain  (normal_gain_r),
    .height_scale (height_scale_r),
    .out_ch       (out_ch)
  );

endmodule

// ----- src/hng_checker.sv -----
module hng_checker #(
  parameter int NORMAL_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hng_pkg::COL_W-1:0]     column,
  input logic [hng_pkg::ROW_W-1:0]     row,
  input logic signed [NORMAL_BITS-1:0] normal_x,
  input logic [NORMAL_BITS-2:0]        normal_y
);
  import hng_pkg::*;

  localparam logic signed [NORMAL_BITS-1:0] ONE_N = NORMAL_BITS'(1) <<< (NORMAL_BITS - 2);
  localparam logic signed [NORMAL_BITS-1:0] NEG_ONE_N = -ONE_N;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(column) && $stable(row)
      && $stable(normal_x))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the front takes one item, then reads the line stores
  a_front_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front accepted during line store read");

  // y is always positive and x stays within the unit range
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> normal_y != '0 && normal_x <= ONE_N && normal_x >= NEG_ONE_N)
    else $error("normal component out of range");

endmodule

bind heightmap_normal_generator hng_checker #(.NORMAL_BITS(NORMAL_BITS)) u_hng_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .column    (out_ch.column),
  .row       (out_ch.row),
  .normal_x  (out_ch.normal_x),
  .normal_y  (out_ch.normal_y)
);
